@@ rtl/ssd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Shared types, segment constants and glyph lookup functions for the
// four-digit serial seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Number of bits in one segment pattern (four digits of eight bits).
	localparam int WORD_BITS = 32;

	// Default number of display chains.
	localparam int NUM_CHAINS_DEF = 20;

	// Fixed patterns: "oflo", "uflo" and the minus sign.
	localparam logic [31:0] PAT_OFLO  = 32'h5c38715c;
	localparam logic [31:0] PAT_UFLO  = 32'h5c38711c;
	localparam logic [7:0]  SEG_MINUS = 8'h40;

	// Display limits.
	localparam logic [15:0] UNSIGNED_LIMIT = 16'd10000;
	localparam logic [16:0] NEG_LIMIT      = 17'd1000;
	localparam logic [16:0] NEG_WRAP       = 17'h10000;

	// Reciprocal multipliers for the decimal split (exact for the ranges used).
	localparam logic [13:0] RECIP_1000 = 14'd8389;  // 2^23 / 1000, rounded up
	localparam int          SHIFT_1000 = 23;
	localparam logic [5:0]  RECIP_100  = 6'd41;     // 2^12 / 100, rounded up
	localparam int          SHIFT_100  = 12;
	localparam logic [7:0]  RECIP_10   = 8'd205;    // 2^11 / 10, rounded up
	localparam int          SHIFT_10   = 11;

	localparam logic [13:0] TEN_3 = 14'd1000;
	localparam logic [9:0]  TEN_2 = 10'd100;
	localparam logic [6:0]  TEN_1 = 7'd10;

	// Character handling.
	localparam logic [3:0] CHAR_DIGIT_NIBBLE = 4'h3;
	localparam logic [7:0] CHAR_LOWER_BIT    = 8'h20;
	localparam logic [7:0] CHAR_LOWER_A      = 8'h61;
	localparam logic [7:0] NUM_LETTERS       = 8'd26;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_UNSIGNED = 2'd0,
		REQ_SIGNED   = 2'd1,
		REQ_CHARS    = 2'd2,
		REQ_RAW      = 2'd3
	} req_kind_t;

	// Input word: one display request.
	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  display_index;
		logic [15:0] number;
		logic [31:0] payload;
	} req_t;

	// Output word: one serial bit.
	typedef struct packed {
		logic       segment_bit;
		logic       latch_strobe;
		logic [4:0] chain_select;
	} ser_t;

	// Segment code of a decimal digit; codes above nine are blank.
	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		logic [7:0] g;
		unique case (d)
			4'd0:    g = 8'h3f;
			4'd1:    g = 8'h06;
			4'd2:    g = 8'h5b;
			4'd3:    g = 8'h4f;
			4'd4:    g = 8'h66;
			4'd5:    g = 8'h6d;
			4'd6:    g = 8'h7d;
			4'd7:    g = 8'h07;
			4'd8:    g = 8'h7f;
			4'd9:    g = 8'h6f;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// Segment code of a letter by alphabet position; beyond 'z' is blank.
	function automatic logic [7:0] letter_glyph(input logic [4:0] i);
		logic [7:0] g;
		unique case (i)
			5'd0:    g = 8'h5f;
			5'd1:    g = 8'h7c;
			5'd2:    g = 8'h58;
			5'd3:    g = 8'h5e;
			5'd4:    g = 8'h7b;
			5'd5:    g = 8'h71;
			5'd6:    g = 8'h6f;
			5'd7:    g = 8'h74;
			5'd8:    g = 8'h04;
			5'd9:    g = 8'h0c;
			5'd10:   g = 8'h76;
			5'd11:   g = 8'h38;
			5'd12:   g = 8'h54;
			5'd13:   g = 8'h54;
			5'd14:   g = 8'h5c;
			5'd15:   g = 8'h73;
			5'd16:   g = 8'h67;
			5'd17:   g = 8'h50;
			5'd18:   g = 8'h6d;
			5'd19:   g = 8'h78;
			5'd20:   g = 8'h1c;
			5'd21:   g = 8'h3e;
			5'd22:   g = 8'h7e;
			5'd23:   g = 8'h76;
			5'd24:   g = 8'h6e;
			5'd25:   g = 8'h5b;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

	// Segment code of one ASCII character: digits, letters of either case,
	// and blank for anything else.
	function automatic logic [7:0] char_glyph(input logic [7:0] c);
		logic [7:0] idx;
		logic [7:0] g;
		idx = (c | CHAR_LOWER_BIT) - CHAR_LOWER_A;
		if (c[7:4] == CHAR_DIGIT_NIBBLE) begin
			g = digit_glyph(c[3:0]);
		end else if (idx < NUM_LETTERS) begin
			g = letter_glyph(idx[4:0]);
		end else begin
			g = 8'h00;
		end
		return g;
	endfunction

endpackage
`default_nettype wire

@@ rtl/seven_segment_serial_display_driver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment serial display driver
// Turns each display request into a 32-bit, four-digit segment pattern and
// shifts it out one bit per word, most significant bit first.
// ----------------------------------------------------------------------------
//
// Usage:
//   req channel (req_valid, req_stall, req) takes one display request per
//   word. Requests that name a chain at or beyond NUM_CHAINS are dropped.
//   res channel (res_valid, res_stall, res) gives 32 words per request, one
//   pattern bit each, with latch_strobe set on the 32nd bit.
//   Four pipeline stages (decode, thousands, hundreds, tens/ones and
//   assembly) feed the output shifter, which gives one bit per cycle
//   while res is not stalled.
//   The single output shifter holds one pattern and loads the next only
//   after its last bit is taken; up to four further requests wait in the
//   pipeline behind it, taken back to back while a pattern is shifted.
//   Reset clears all valid bits and the bit counter; no words are in flight.
//   A stall on res holds the current bit; the pipeline fills behind it and
//   req_stall rises only once every stage holds a request.
//
module seven_segment_serial_display_driver #(
	parameter int NUM_CHAINS = ssd_pkg::NUM_CHAINS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ssd_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_stall,
	output ssd_pkg::ser_t      res
);

	localparam logic [4:0] LAST_BIT = 5'(ssd_pkg::WORD_BITS - 1);

	// Stage enables and handshake.
	logic en_s1, en_s2, en_s3, en_s4;
	logic req_take, res_take, sh_last, sh_free;
	logic chain_ok;

	// Stage 1: decode.
	logic        v_s1, dec_s1, minus_s1;
	logic [31:0] word_s1;
	logic [13:0] mag_s1;
	logic [4:0]  chain_s1;

	// Stage 2: thousands.
	logic        v_s2, dec_s2, minus_s2;
	logic [31:0] word_s2;
	logic [3:0]  thou_s2;
	logic [9:0]  rem_s2;
	logic [4:0]  chain_s2;

	// Stage 3: hundreds.
	logic        v_s3, dec_s3, minus_s3;
	logic [31:0] word_s3;
	logic [3:0]  thou_s3, hund_s3;
	logic [6:0]  rem_s3;
	logic [4:0]  chain_s3;

	// Stage 4: final pattern.
	logic        v_s4;
	logic [31:0] word_s4;
	logic [4:0]  chain_s4;

	// Output shifter.
	logic        sh_valid_q;
	logic [4:0]  sh_cnt_q;
	logic [31:0] sh_word_q;
	logic [4:0]  sh_chain_q;

	// Combinational stage results.
	logic        dec_c, minus_c;
	logic [31:0] word_c;
	logic [13:0] mag_c;
	logic [16:0] mag_neg_c;
	logic [27:0] prod_th_c;
	logic [3:0]  thou_c;
	logic [13:0] sub_th_c;
	logic [15:0] prod_hu_c;
	logic [3:0]  hund_c;
	logic [9:0]  sub_hu_c;
	logic [14:0] prod_te_c;
	logic [3:0]  tens_c, ones_c;
	logic [6:0]  sub_te_c;
	logic [31:0] dec_word_c;

	// Handshake and stage advance: a stage moves when it is empty or the
	// next one moves.
	assign res_take  = res_valid && !res_stall;
	assign sh_last   = (sh_cnt_q == LAST_BIT);
	assign sh_free   = !sh_valid_q || (res_take && sh_last);
	assign en_s4     = !v_s4 || sh_free;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign req_stall = !en_s1;
	assign req_take  = req_valid && en_s1;
	assign chain_ok  = (32'(req.display_index) < 32'(NUM_CHAINS));

	// Decode: special patterns, text and raw payloads go straight into the
	// word, numbers leave a magnitude below 10000 for the decimal stages.
	always_comb begin
		dec_c     = 1'b0;
		minus_c   = 1'b0;
		word_c    = req.payload;
		mag_c     = req.number[13:0];
		mag_neg_c = ssd_pkg::NEG_WRAP - {1'b0, req.number};
		unique case (req.req_type)
			ssd_pkg::REQ_UNSIGNED: begin
				if (req.number >= ssd_pkg::UNSIGNED_LIMIT) begin
					word_c = ssd_pkg::PAT_OFLO;
				end else begin
					dec_c = 1'b1;
				end
			end
			ssd_pkg::REQ_SIGNED: begin
				if (req.number[15]) begin
					if (mag_neg_c >= ssd_pkg::NEG_LIMIT) begin
						word_c = ssd_pkg::PAT_UFLO;
					end else begin
						dec_c   = 1'b1;
						minus_c = 1'b1;
						mag_c   = mag_neg_c[13:0];
					end
				end else if (req.number >= ssd_pkg::UNSIGNED_LIMIT) begin
					word_c = ssd_pkg::PAT_OFLO;
				end else begin
					dec_c = 1'b1;
				end
			end
			ssd_pkg::REQ_CHARS: begin
				word_c = {ssd_pkg::char_glyph(req.payload[31:24]),
					ssd_pkg::char_glyph(req.payload[23:16]),
					ssd_pkg::char_glyph(req.payload[15:8]),
					ssd_pkg::char_glyph(req.payload[7:0])};
			end
			ssd_pkg::REQ_RAW: begin
				word_c = req.payload;
			end
			default: begin
				word_c = req.payload;
			end
		endcase
	end

	// Thousands digit and remainder by reciprocal multiply.
	always_comb begin
		prod_th_c = 28'(mag_s1) * 28'(ssd_pkg::RECIP_1000);
		thou_c    = prod_th_c[ssd_pkg::SHIFT_1000 +: 4];
		sub_th_c  = 14'(thou_c) * ssd_pkg::TEN_3;
	end

	// Hundreds digit and remainder.
	always_comb begin
		prod_hu_c = 16'(rem_s2) * 16'(ssd_pkg::RECIP_100);
		hund_c    = prod_hu_c[ssd_pkg::SHIFT_100 +: 4];
		sub_hu_c  = 10'(hund_c) * ssd_pkg::TEN_2;
	end

	// Tens and ones digits, leading-zero blanking and pattern assembly.
	always_comb begin
		prod_te_c  = 15'(rem_s3) * 15'(ssd_pkg::RECIP_10);
		tens_c     = prod_te_c[ssd_pkg::SHIFT_10 +: 4];
		sub_te_c   = 7'(tens_c) * ssd_pkg::TEN_1;
		ones_c     = 4'(rem_s3 - sub_te_c);
		dec_word_c = {ssd_pkg::digit_glyph(ones_c), 24'h000000};
		if (thou_s3 != 4'd0 || hund_s3 != 4'd0 || tens_c != 4'd0) begin
			dec_word_c[23:16] = ssd_pkg::digit_glyph(tens_c);
		end
		if (thou_s3 != 4'd0 || hund_s3 != 4'd0) begin
			dec_word_c[15:8] = ssd_pkg::digit_glyph(hund_s3);
		end
		if (thou_s3 != 4'd0) begin
			dec_word_c[7:0] = ssd_pkg::digit_glyph(thou_s3);
		end
		if (minus_s3) begin
			dec_word_c[7:0] = dec_word_c[7:0] | ssd_pkg::SEG_MINUS;
		end
	end

	// Valid bits of the pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= req_take && chain_ok;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Payload of the pipeline stages.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			dec_s1   <= dec_c;
			minus_s1 <= minus_c;
			word_s1  <= word_c;
			mag_s1   <= mag_c;
			chain_s1 <= req.display_index;
		end
		if (en_s2) begin
			dec_s2   <= dec_s1;
			minus_s2 <= minus_s1;
			word_s2  <= word_s1;
			thou_s2  <= thou_c;
			rem_s2   <= 10'(mag_s1 - sub_th_c);
			chain_s2 <= chain_s1;
		end
		if (en_s3) begin
			dec_s3   <= dec_s2;
			minus_s3 <= minus_s2;
			word_s3  <= word_s2;
			thou_s3  <= thou_s2;
			hund_s3  <= hund_c;
			rem_s3   <= 7'(rem_s2 - sub_hu_c);
			chain_s3 <= chain_s2;
		end
		if (en_s4) begin
			word_s4  <= dec_s3 ? dec_word_c : word_s3;
			chain_s4 <= chain_s3;
		end
	end

	// Shifter control: load a new pattern when idle or after the last bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_valid_q <= 1'b0;
			sh_cnt_q   <= '0;
		end else if (sh_free) begin
			sh_valid_q <= v_s4;
			sh_cnt_q   <= '0;
		end else if (res_take) begin
			sh_cnt_q <= sh_cnt_q + 5'd1;
		end
	end

	// Shifter data: the top bit is the bit on the output.
	always_ff @(posedge clk) begin
		if (sh_free && v_s4) begin
			sh_word_q  <= word_s4;
			sh_chain_q <= chain_s4;
		end else if (res_take) begin
			sh_word_q <= {sh_word_q[30:0], 1'b0};
		end
	end

	// Output word.
	assign res_valid          = sh_valid_q;
	assign res.segment_bit    = sh_word_q[31];
	assign res.latch_strobe   = sh_last;
	assign res.chain_select   = sh_chain_q;

endmodule
`default_nettype wire

@@ rtl/ssd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment driver port checker
// Watches the driver ports: framing, stalled words and chain range.
// ----------------------------------------------------------------------------
module ssd_checker #(
	parameter int NUM_CHAINS = ssd_pkg::NUM_CHAINS_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire ssd_pkg::req_t req,
	input wire logic          res_valid,
	input wire logic          res_stall,
	input wire ssd_pkg::ser_t res
);

	localparam logic [4:0] LAST_BIT = 5'(ssd_pkg::WORD_BITS - 1);

	logic       res_take;
	logic [4:0] bit_cnt_q;

	assign res_take = res_valid && !res_stall;

	// Position of the current bit within its pattern.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else if (res_take) begin
			bit_cnt_q <= bit_cnt_q + 5'd1;
		end
	end

	// A stalled output word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("output word changed while stalled");

	// The latch strobe marks exactly every 32nd bit.
	a_strobe_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.latch_strobe == (bit_cnt_q == LAST_BIT)))
		else $error("latch strobe out of place");

	// A pattern is sent without gaps and to one chain.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && !res.latch_strobe |=> res_valid && $stable(res.chain_select))
		else $error("pattern interrupted or chain changed mid pattern");

	// Only existing chains are driven.
	a_chain_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (32'(res.chain_select) < 32'(NUM_CHAINS)))
		else $error("chain select beyond the last chain");

	// A stalled request word holds until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request word changed while stalled");

endmodule

bind seven_segment_serial_display_driver ssd_checker #(
	.NUM_CHAINS(NUM_CHAINS)
) u_ssd_checker (.*);
`default_nettype wire
